// ----- hdl/jan_pkg.sv -----
// ----------------------------------------------------------------------------
// jan_pkg
// Shared types and constants for the joystick auto-ranging normalizer:
// payload structs, controller command and status groups, and reset values.
// ----------------------------------------------------------------------------
package jan_pkg;

  localparam int CONTROLLERS_DEF = 4;
  localparam int FRAC_BITS_DEF   = 14;

  localparam int OUT_W    = 16;
  localparam int MARGIN_W = 6;

  localparam logic [7:0]          RANGE_RESET  = 8'd64;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 6'd10;

  typedef struct packed {
    logic signed [2:0] controller_index;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
  } jan_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] norm_x;
    logic signed [OUT_W-1:0] norm_y;
  } jan_out_t;

  typedef struct packed {
    logic load;
    logic range_upd;
    logic clamp;
    logic square;
    logic prep;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic finish;
  } jan_cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic unit_mode;
  } jan_sts_t;

endpackage

// ----- hdl/jan_lane.sv -----
// ----------------------------------------------------------------------------
// jan_lane
// One axis of the normalizer: a shared restoring divider and a digit-by-digit
// square root unit that produce the rounded magnitude of one output axis.
// ----------------------------------------------------------------------------
module jan_lane
  import jan_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               load,
  input  logic               mode,
  input  logic [7:0]         a,
  input  logic [14:0]        a_sq,
  input  logic [15:0]        s,
  input  logic [7:0]         d,
  input  logic               div_step,
  input  logic               sqrt_load,
  input  logic               sqrt_step,
  output logic [FRAC_BITS:0] result
);

  localparam int QW  = 2 * FRAC_BITS + 3;
  localparam int SQW = FRAC_BITS + 2;

  logic              mode_r;
  logic [15:0]       rem_r;
  logic [15:0]       dv_r;
  logic [QW-1:0]     sh_r;
  logic [QW-1:0]     quo_r;
  logic [2*SQW-1:0]  sq_op_r;
  logic [SQW:0]      sq_rem_r;
  logic [SQW-1:0]    root_r;

  logic [16:0]       rem_sh;
  logic              div_ge;
  logic [16:0]       rem_sub;
  logic [1:0]        pair;
  logic [SQW+2:0]    rem4;
  logic [SQW+2:0]    trial;
  logic              sq_ge;
  logic [SQW+2:0]    rem4_sub;
  logic [SQW:0]      rnd;

  always_comb begin
    rem_sh   = {rem_r, sh_r[QW-1]};
    div_ge   = rem_sh >= {1'b0, dv_r};
    rem_sub  = rem_sh - {1'b0, dv_r};
    pair     = sq_op_r[2*SQW-1 -: 2];
    rem4     = {sq_rem_r, pair};
    trial    = {1'b0, root_r, 2'b01};
    sq_ge    = rem4 >= trial;
    rem4_sub = rem4 - trial;
    rnd      = {1'b0, root_r} + {{SQW{1'b0}}, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mode_r <= mode;
      quo_r  <= '0;
      if (mode) begin
        rem_r <= {2'b00, a_sq[14:1]};
        dv_r  <= s;
        sh_r  <= {a_sq[0], {(QW-1){1'b0}}};
      end else begin
        rem_r <= {8'b0, a};
        dv_r  <= {7'b0, d, 1'b0};
        sh_r  <= {{(FRAC_BITS-7){1'b0}}, d, {(FRAC_BITS+2){1'b0}}};
      end
    end else if (div_step) begin
      rem_r <= div_ge ? rem_sub[15:0] : rem_sh[15:0];
      quo_r <= {quo_r[QW-2:0], div_ge};
      sh_r  <= {sh_r[QW-2:0], 1'b0};
    end
    if (sqrt_load) begin
      sq_op_r  <= {1'b0, quo_r};
      sq_rem_r <= '0;
      root_r   <= '0;
    end else if (sqrt_step) begin
      sq_op_r  <= {sq_op_r[2*SQW-3:0], 2'b00};
      sq_rem_r <= sq_ge ? rem4_sub[SQW:0] : rem4[SQW:0];
      root_r   <= {root_r[SQW-2:0], sq_ge};
    end
  end

  assign result = mode_r ? rnd[FRAC_BITS+1:1] : quo_r[FRAC_BITS:0];

endmodule

// ----- hdl/jan_datapath.sv -----
// ----------------------------------------------------------------------------
// jan_datapath
// Learned range store, range update, clamping, squaring, mode selection,
// two axis lanes and the registered, saturated output.
// ----------------------------------------------------------------------------
module jan_datapath
  import jan_pkg::*;
#(
  parameter int CONTROLLERS = CONTROLLERS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  jan_cmd_t            cmd,
  output jan_sts_t            sts,
  input  jan_in_t             in_data,
  input  logic                cfg_we,
  input  logic [MARGIN_W-1:0] cfg_data,
  output jan_out_t            out_data
);

  localparam int SEL_W = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;
  localparam logic [2:0] CTRL_LIM = 3'(CONTROLLERS);
  localparam int EW = (FRAC_BITS + 2 > OUT_W) ? FRAC_BITS + 2 : OUT_W + 1;
  localparam logic signed [EW-1:0] POS_LIM = EW'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [EW-1:0] NEG_LIM = EW'(-(1 << (OUT_W - 1)));

  logic [MARGIN_W-1:0] margin_r;
  logic [7:0]          range_r [CONTROLLERS];
  jan_in_t             item_r;
  logic [7:0]          rng_r;
  logic [7:0]          d_r;
  logic [7:0]          ax_r;
  logic [7:0]          ay_r;
  logic                neg_x_r;
  logic                neg_y_r;
  logic [15:0]         axsq_r;
  logic [15:0]         aysq_r;
  logic [15:0]         dsq_r;
  logic                unit_r;
  jan_out_t            out_data_r;

  logic [SEL_W-1:0]    sel;
  logic                idx_ok;
  logic signed [9:0]   x_ext;
  logic signed [9:0]   y_ext;
  logic signed [9:0]   r0;
  logic signed [9:0]   r1;
  logic signed [9:0]   r2;
  logic [7:0]          d_val;
  logic [7:0]          ux;
  logic [7:0]          uy;
  logic [15:0]         s_sum;
  logic                unit_sel;
  logic [FRAC_BITS:0]  res_x;
  logic [FRAC_BITS:0]  res_y;

  function automatic logic [OUT_W-1:0] fmt(input logic neg, input logic [FRAC_BITS:0] mag);
    logic signed [EW-1:0] ve;
    ve = signed'(EW'(mag));
    if (neg) begin
      ve = -ve;
    end
    if (ve > POS_LIM) begin
      return POS_LIM[OUT_W-1:0];
    end else if (ve < NEG_LIM) begin
      return NEG_LIM[OUT_W-1:0];
    end
    return ve[OUT_W-1:0];
  endfunction

  always_comb begin
    sel    = item_r.controller_index[SEL_W-1:0];
    idx_ok = !item_r.controller_index[2] && (3'(item_r.controller_index) < CTRL_LIM);
    x_ext  = 10'(item_r.stick_x);
    y_ext  = 10'(item_r.stick_y);
    r0     = signed'({2'b00, range_r[sel]});
    if (x_ext > r0) begin
      r1 = x_ext;
    end else if (x_ext < -r0) begin
      r1 = -x_ext;
    end else begin
      r1 = r0;
    end
    if (y_ext > r1) begin
      r2 = y_ext;
    end else if (y_ext < -r1) begin
      r2 = -y_ext;
    end else begin
      r2 = r1;
    end
    d_val    = rng_r - {2'b00, margin_r};
    ux       = item_r.stick_x[7] ? (~item_r.stick_x + 8'd1) : item_r.stick_x;
    uy       = item_r.stick_y[7] ? (~item_r.stick_y + 8'd1) : item_r.stick_y;
    s_sum    = axsq_r + aysq_r;
    unit_sel = s_sum > dsq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RESET;
      for (int i = 0; i < CONTROLLERS; i++) begin
        range_r[i] <= RANGE_RESET;
      end
    end else begin
      if (cfg_we) begin
        margin_r <= cfg_data;
      end
      if (cmd.range_upd && idx_ok) begin
        range_r[sel] <= r2[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.range_upd) begin
      rng_r <= r2[7:0];
    end
    if (cmd.clamp) begin
      d_r     <= d_val;
      ax_r    <= (ux > d_val) ? d_val : ux;
      ay_r    <= (uy > d_val) ? d_val : uy;
      neg_x_r <= item_r.stick_x[7];
      neg_y_r <= !item_r.stick_y[7] && (item_r.stick_y != 8'sd0);
    end
    if (cmd.square) begin
      axsq_r <= ax_r * ax_r;
      aysq_r <= ay_r * ay_r;
      dsq_r  <= d_r * d_r;
    end
    if (cmd.prep) begin
      unit_r <= unit_sel;
    end
    if (cmd.finish) begin
      if (idx_ok) begin
        out_data_r.norm_x <= fmt(neg_x_r, res_x);
        out_data_r.norm_y <= fmt(neg_y_r, res_y);
      end else begin
        out_data_r <= '0;
      end
    end
  end

  jan_lane #(
    .FRAC_BITS(FRAC_BITS)
  ) u_lane_x (
    .clk      (clk),
    .load     (cmd.prep),
    .mode     (unit_sel),
    .a        (ax_r),
    .a_sq     (axsq_r[14:0]),
    .s        (s_sum),
    .d        (d_r),
    .div_step (cmd.div_step),
    .sqrt_load(cmd.sqrt_load),
    .sqrt_step(cmd.sqrt_step),
    .result   (res_x)
  );

  jan_lane #(
    .FRAC_BITS(FRAC_BITS)
  ) u_lane_y (
    .clk      (clk),
    .load     (cmd.prep),
    .mode     (unit_sel),
    .a        (ay_r),
    .a_sq     (aysq_r[14:0]),
    .s        (s_sum),
    .d        (d_r),
    .div_step (cmd.div_step),
    .sqrt_load(cmd.sqrt_load),
    .sqrt_step(cmd.sqrt_step),
    .result   (res_y)
  );

  assign sts.idx_ok    = idx_ok;
  assign sts.unit_mode = unit_r;
  assign out_data      = out_data_r;

endmodule

// ----- hdl/jan_ctrl.sv -----
// ----------------------------------------------------------------------------
// jan_ctrl
// Sequencer for one item at a time: issues datapath commands, counts divider
// and square root steps, and owns the output valid flag.
// ----------------------------------------------------------------------------
module jan_ctrl
  import jan_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  jan_sts_t sts,
  output jan_cmd_t cmd
);

  localparam int QW  = 2 * FRAC_BITS + 3;
  localparam int SQW = FRAC_BITS + 2;
  localparam int CW  = $clog2(QW);
  localparam logic [CW-1:0] DIV_NORM_LAST = CW'(FRAC_BITS);
  localparam logic [CW-1:0] DIV_UNIT_LAST = CW'(QW - 1);
  localparam logic [CW-1:0] ROOT_LAST     = CW'(SQW - 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_RANGE   = 9'b000000010,
    S_CLAMP   = 9'b000000100,
    S_SQUARE  = 9'b000001000,
    S_PREP    = 9'b000010000,
    S_DIV     = 9'b000100000,
    S_ROOT_LD = 9'b001000000,
    S_ROOT    = 9'b010000000,
    S_FINISH  = 9'b100000000
  } state_t;

  state_t        state_r;
  state_t        state_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic          out_free;
  logic [CW-1:0] div_last;

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    div_last  = sts.unit_mode ? DIV_UNIT_LAST : DIV_NORM_LAST;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        cmd.range_upd = 1'b1;
        state_nxt     = sts.idx_ok ? S_CLAMP : S_FINISH;
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == div_last) begin
          cnt_nxt   = '0;
          state_nxt = sts.unit_mode ? S_ROOT_LD : S_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ROOT_LD: begin
        cmd.sqrt_load = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == ROOT_LAST) begin
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FINISH: begin
        cmd.finish = out_free;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- hdl/joystick_autorange_normalizer.sv -----
// The path from input transfer to output valid depends on the case: an absent controller
// skips the lanes, a sample inside the unit circle uses the divider alone, and one outside
// it the divider and then the square root, each lane making one bit per cycle. One item is
// in work at a time; the next input transfer can be taken once the result is registered.
// Synchronous active-low reset sets every learned range to 64 and the margin to 10.
// ----------------------------------------------------------------------------
// joystick_autorange_normalizer
// Learns a stick range per controller, scales the clamped sample by the range
// minus the outer margin, and limits the vector to unit length.
// ----------------------------------------------------------------------------
module joystick_autorange_normalizer
  import jan_pkg::*;
#(
  parameter int CONTROLLERS = CONTROLLERS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  jan_in_t             in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output jan_out_t            out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MARGIN_W-1:0] cfg_data
);

  jan_cmd_t cmd;
  jan_sts_t sts;

  assign cfg_ready = 1'b1;

  jan_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jan_datapath #(
    .CONTROLLERS(CONTROLLERS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_data (in_data),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("More than one datapath command issued in a cycle.");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input taken again directly after a transfer.");

  a_root_unit_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqrt_step |-> sts.unit_mode)
    else $error("Square root step outside the unit-length case.");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("Finished result not presented at the output.");
`endif

endmodule

// ----- tb/sv/joystick_autorange_normalizer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_autorange_normalizer_tb
// Drives stick samples into the normalizer under random idling on both sides.
// It checks every result transfer against a predictor that learns the stick
// range per controller and scales, clamps and limits each vector on its own.
// ----------------------------------------------------------------------------
module joystick_autorange_normalizer_tb;
  import jan_pkg::*;

  localparam int F              = FRAC_BITS_DEF;
  localparam int CTRL_N         = CONTROLLERS_DEF;
  localparam int SEGMENTS       = 6;
  localparam int SEG_ITEMS      = 142;
  localparam int RANDOM_ITEMS   = SEGMENTS * SEG_ITEMS;
  localparam int DRAIN_CYCLES   = 3 * F + 20;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  jan_in_t             in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  jan_out_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [MARGIN_W-1:0] cfg_data = '0;

  jan_in_t  pending_samples[$];
  jan_out_t expected_norm[$];

  logic [7:0]          stick_range [CTRL_N];
  logic [MARGIN_W-1:0] margin_q;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int sample_no = 0;

  joystick_autorange_normalizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  function automatic int unsigned unit_scale(input int unsigned a,
                                             input longint unsigned sq);
    longint unsigned goal;
    longint unsigned acc;
    longint unsigned cand;
    longint unsigned t;
    goal = (longint'(a) * longint'(a)) << (2 * F + 2);
    acc = 0;
    for (int b = F; b >= 0; b--) begin
      cand = acc | (64'd1 << b);
      if (cand <= (64'd1 << F)) begin
        t = 2 * cand - 1;
        if (t * t * sq <= goal) acc = cand;
      end
    end
    return int'(acc);
  endfunction

  function automatic jan_out_t normalize_sample(input jan_in_t s);
    int idx, x, y, rng, d, cx, cy, ax, ay, mx, my;
    longint unsigned sq;
    jan_out_t r;
    r = '0;
    idx = $signed(s.controller_index);
    x = $signed(s.stick_x);
    y = $signed(s.stick_y);
    if (idx < 0 || idx >= CTRL_N) return r;
    rng = stick_range[idx];
    if (x > rng) rng = x;
    else if (x < -rng) rng = -x;
    if (y > rng) rng = y;
    else if (y < -rng) rng = -y;
    stick_range[idx] = rng[7:0];
    d = rng - int'(margin_q);
    cx = (x > d) ? d : ((x < -d) ? -d : x);
    cy = (-y > d) ? d : ((-y < -d) ? -d : -y);
    ax = (cx < 0) ? -cx : cx;
    ay = (cy < 0) ? -cy : cy;
    sq = longint'(ax * ax + ay * ay);
    if (sq > longint'(d * d)) begin
      mx = unit_scale(ax, sq);
      my = unit_scale(ay, sq);
    end else begin
      mx = ((ax << (F + 1)) + d) / (2 * d);
      my = ((ay << (F + 1)) + d) / (2 * d);
    end
    r.norm_x = OUT_W'((cx < 0) ? -mx : mx);
    r.norm_y = OUT_W'((cy < 0) ? -my : my);
    return r;
  endfunction

  function automatic jan_in_t mk_sample(input int idx, input int x, input int y);
    jan_in_t s;
    s.controller_index = idx[2:0];
    s.stick_x = x[7:0];
    s.stick_y = y[7:0];
    return s;
  endfunction

  function automatic int random_axis();
    int lim, k, v;
    lim = 50 + (sample_no * 80) / RANDOM_ITEMS;
    if (lim > 128) lim = 128;
    k = $urandom_range(0, 99);
    if (k < 8 && sample_no > (3 * RANDOM_ITEMS) / 4) begin
      v = $urandom_range(0, 255) - 128;
    end else if (k < 16) begin
      v = $urandom_range(0, 1) ? lim : -lim;
    end else begin
      v = $urandom_range(0, 2 * lim) - lim;
    end
    if (v > 127) v = 127;
    return v;
  endfunction

  task automatic add_random_samples(input int count);
    int k, idx;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      if (k < 6) idx = -1;
      else if (k < 10) idx = -$urandom_range(2, 4);
      else idx = $urandom_range(0, CTRL_N - 1);
      pending_samples.push_back(mk_sample(idx, random_axis(), random_axis()));
      sample_no++;
    end
  endtask

  task automatic wait_for_idle();
    while (pending_samples.size() != 0 || in_valid || expected_norm.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_margin(input logic [MARGIN_W-1:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    margin_q = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_norm.push_back(normalize_sample(in_data));
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    jan_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_norm.size() == 0) begin
          report_mismatch("result transfer with nothing expected, norm_x",
                          $signed(out_data.norm_x), 0);
        end else begin
          want = expected_norm.pop_front();
          if (out_data.norm_x !== want.norm_x)
            report_mismatch("norm_x", $signed(out_data.norm_x), $signed(want.norm_x));
          if (out_data.norm_y !== want.norm_y)
            report_mismatch("norm_y", $signed(out_data.norm_y), $signed(want.norm_y));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < CTRL_N; i++) stick_range[i] = RANGE_RESET;
    margin_q = MARGIN_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 65;
    // Absent controller and out-of-range indexes leave the ranges alone.
    pending_samples.push_back(mk_sample(-1, 127, -128));
    pending_samples.push_back(mk_sample(-4, -128, 127));
    pending_samples.push_back(mk_sample(-3, 127, 127));
    pending_samples.push_back(mk_sample(-2, -128, -128));
    pending_samples.push_back(mk_sample(0, 0, 0));
    pending_samples.push_back(mk_sample(0, 54, 0));
    pending_samples.push_back(mk_sample(0, -54, 0));
    pending_samples.push_back(mk_sample(0, 0, -54));
    pending_samples.push_back(mk_sample(0, 0, 54));
    pending_samples.push_back(mk_sample(0, 40, 40));
    pending_samples.push_back(mk_sample(0, 20, -10));
    pending_samples.push_back(mk_sample(0, 1, -1));
    pending_samples.push_back(mk_sample(0, -1, 1));
    pending_samples.push_back(mk_sample(0, 64, -64));
    pending_samples.push_back(mk_sample(1, 100, 0));
    pending_samples.push_back(mk_sample(1, 0, 120));
    pending_samples.push_back(mk_sample(1, 60, -60));
    pending_samples.push_back(mk_sample(2, 70, -90));
    pending_samples.push_back(mk_sample(2, -128, 127));
    pending_samples.push_back(mk_sample(2, 3, -5));
    pending_samples.push_back(mk_sample(3, 127, 127));
    pending_samples.push_back(mk_sample(3, -128, -128));
    pending_samples.push_back(mk_sample(3, 85, 2));

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_for_idle();
      case (seg)
        0: write_margin(6'd63);
        1: write_margin(6'd0);
        SEGMENTS - 1: write_margin(6'd63);
        default: write_margin(MARGIN_W'($urandom_range(0, 63)));
      endcase
      if (seg < 2) begin
        send_idle_pct = 7;
        recv_idle_pct = 65;
      end else if (seg < 4) begin
        send_idle_pct = 65;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      add_random_samples(SEG_ITEMS);
    end

    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- joystick_autorange_normalizer.f -----
hdl/jan_pkg.sv
hdl/jan_lane.sv
hdl/jan_datapath.sv
hdl/jan_ctrl.sv
hdl/joystick_autorange_normalizer.sv
tb/sv/joystick_autorange_normalizer_tb.sv
